// ----- sv/xpp_pkg.sv -----
// Shared types, constants and helpers for the XRGB pixel packer.
`default_nettype none

package xpp_pkg;

  typedef enum logic [1:0] {
    FMT_NONE   = 2'd0,
    FMT_RGB233 = 2'd1,
    FMT_RGB565 = 2'd2,
    FMT_RGB888 = 2'd3
  } xpp_fmt_e;

  localparam xpp_fmt_e FMT_RESET = FMT_RGB888;

  localparam int unsigned PIX_W  = 24;
  localparam int unsigned WORD_W = 64;

  // Stream byte k of a word goes to lane k ^ 4: 32-bit halves swapped.
  localparam logic [2:0] LANE_SWAP = 3'd4;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } xpp_res_t;

  // Up to two results produced by one item.
  typedef struct packed {
    logic [1:0] cnt;
    xpp_res_t   r0;
    xpp_res_t   r1;
  } xpp_push_t;

  function automatic logic [2:0] xpp_lane(logic [2:0] k);
    return k ^ LANE_SWAP;
  endfunction

endpackage

`default_nettype wire

// ----- sv/xpp_fmt.sv -----
// Pixel format conversion: XRGB8888 to RGB233, RGB565 or RGB888 bytes.
`default_nettype none

module xpp_fmt
  import xpp_pkg::*;
(
  input  wire logic [PIX_W-1:0] pixel_i,
  input  wire xpp_fmt_e         fmt_i,
  output logic [2:0][7:0]       bytes_o,
  output logic [1:0]            nbytes_o
);

  logic [15:0] rgb565;

  assign rgb565 = {pixel_i[23:19], pixel_i[15:10], pixel_i[7:3]};

  always_comb begin
    bytes_o  = '0;
    nbytes_o = 2'd0;
    case (fmt_i)
      FMT_RGB233: begin
        bytes_o[0] = {pixel_i[23:22], pixel_i[15:13], pixel_i[7:5]};
        nbytes_o   = 2'd1;
      end
      FMT_RGB565: begin
        bytes_o[0] = rgb565[7:0];
        bytes_o[1] = rgb565[15:8];
        nbytes_o   = 2'd2;
      end
      FMT_RGB888: begin
        // blue, green, red in stream order
        bytes_o[0] = pixel_i[7:0];
        bytes_o[1] = pixel_i[15:8];
        bytes_o[2] = pixel_i[23:16];
        nbytes_o   = 2'd3;
      end
      default: begin
        bytes_o  = '0;
        nbytes_o = 2'd0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/xpp_acc.sv -----
// Word accumulator: places pixel bytes at swizzled lanes, emits full and flushed words.
`default_nettype none

module xpp_acc
  import xpp_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            take_i,
  input  wire logic [2:0][7:0] bytes_i,
  input  wire logic [1:0]      nbytes_i,
  input  wire logic            fend_i,
  output xpp_push_t            push_o
);

  logic [WORD_W-1:0] acc_q, acc_d;
  logic [2:0]        fill_q, fill_d;
  logic [15:0][7:0]  ext;
  logic [3:0]        pos;
  logic [3:0]        tot;
  logic              full;
  logic              extra;
  logic [WORD_W-1:0] nxt;

  // Two-word window: current word plus the start of the next one.
  always_comb begin
    ext      = '0;
    ext[7:0] = acc_q;
    pos      = '0;
    for (int i = 0; i < 3; i++) begin
      pos = {1'b0, fill_q} + 4'(i);
      if (2'(i) < nbytes_i) begin
        ext[{pos[3], xpp_lane(pos[2:0])}] = ext[{pos[3], xpp_lane(pos[2:0])}] | bytes_i[i];
      end
    end
  end

  assign tot   = {1'b0, fill_q} + {2'b00, nbytes_i};
  assign full  = tot[3];
  assign nxt   = full ? ext[15:8] : ext[7:0];
  // frame end needs its own word unless the completed word ends exactly there
  assign extra = fend_i && ((tot[2:0] != 3'd0) || !full);

  always_comb begin
    push_o.cnt = {1'b0, full} + {1'b0, extra};
    if (full) begin
      push_o.r0 = '{word: ext[7:0], last: fend_i && (tot[2:0] == 3'd0)};
      push_o.r1 = '{word: nxt, last: 1'b1};
    end else begin
      push_o.r0 = '{word: nxt, last: 1'b1};
      push_o.r1 = '{word: nxt, last: 1'b1};
    end
  end

  always_comb begin
    acc_d  = acc_q;
    fill_d = fill_q;
    if (take_i) begin
      if (fend_i) begin
        acc_d  = '0;
        fill_d = '0;
      end else begin
        acc_d  = nxt;
        fill_d = tot[2:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      fill_q <= '0;
    end else begin
      acc_q  <= acc_d;
      fill_q <= fill_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/xpp_rq.sv -----
// Two-entry result queue feeding the output stream.
`default_nettype none

module xpp_rq
  import xpp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire xpp_push_t push_i,
  input  wire logic      ready_i,
  output logic           valid_o,
  output xpp_res_t       res_o,
  output logic [1:0]     level_o
);

  logic [1:0] cnt_q, cnt_d;
  xpp_res_t   e0_q, e0_d;
  xpp_res_t   e1_q, e1_d;
  logic       pop;
  logic [1:0] base;

  assign pop  = (cnt_q != 2'd0) && ready_i;
  assign base = cnt_q - {1'b0, pop};

  always_comb begin
    e0_d = e0_q;
    e1_d = e1_q;
    if (pop) begin
      e0_d = e1_q;
    end
    case (base)
      2'd0: begin
        e0_d = push_i.r0;
        e1_d = push_i.r1;
      end
      2'd1: begin
        e1_d = push_i.r0;
      end
      default: begin
      end
    endcase
    cnt_d = base + push_i.cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

  assign valid_o = cnt_q != 2'd0;
  assign res_o   = e0_q;
  assign level_o = cnt_q;

endmodule

`default_nettype wire

// ----- sv/xrgb_pixel_packer_swizzled_unit.sv -----
// A pixel is registered in the input stage and its words in the result queue.
// Throughput: one pixel per cycle while the result queue has room; a frame-end
// pixel that yields two words fills the two-entry queue and may hold the input.
// Reset (async, active low) clears the word accumulator, fill count, queue and
// input stage; the format register returns to RGB888.
`default_nettype none

module xrgb_pixel_packer_swizzled_unit
  import xpp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration write: bytes_per_pixel
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_data_i,
  // input pixels
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [PIX_W-1:0]  s_axis_tdata,  // [23:0] pixel
  input  wire logic              s_axis_tlast,  // frame_end
  // packed words
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [WORD_W-1:0]      m_axis_tdata,  // [63:0] packed_word
  output logic                   m_axis_tlast   // word_last
);

  xpp_fmt_e         fmt_q;
  logic             s1_valid_q, s1_valid_d;
  logic [PIX_W-1:0] s1_pix_q;
  logic             s1_fend_q;
  logic [2:0][7:0]  bytes;
  logic [1:0]       nbytes;
  xpp_push_t        push;
  xpp_push_t        push_g;
  logic [1:0]       level;
  logic             proceed;
  xpp_res_t         res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fmt_q <= xpp_fmt_e'(cfg_data_i);
    end
  end

  // input stage
  assign proceed       = s1_valid_q && (({1'b0, level} + {1'b0, push.cnt}) <= 3'd2);
  assign s_axis_tready = !s1_valid_q || proceed;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s_axis_tready) begin
      s1_valid_d = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_pix_q  <= s_axis_tdata;
      s1_fend_q <= s_axis_tlast;
    end
  end

  xpp_fmt u_fmt (
    .pixel_i  (s1_pix_q),
    .fmt_i    (fmt_q),
    .bytes_o  (bytes),
    .nbytes_o (nbytes)
  );

  xpp_acc u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (proceed),
    .bytes_i  (bytes),
    .nbytes_i (nbytes),
    .fend_i   (s1_fend_q),
    .push_o   (push)
  );

  always_comb begin
    push_g = push;
    if (!proceed) begin
      push_g.cnt = 2'd0;
    end
  end

  xpp_rq u_rq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_g),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .res_o   (res),
    .level_o (level)
  );

  assign m_axis_tdata = res.word;
  assign m_axis_tlast = res.last;

`ifndef SYNTHESIS
  a_level_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    level != 2'd3)
    else $error("result queue overflow");

  a_fend_marks_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proceed && s1_fend_q) |->
      ((push.cnt == 2'd1 && push.r0.last) || (push.cnt == 2'd2 && push.r1.last)))
    else $error("frame end without a last word");

  a_two_only_at_fend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proceed && push.cnt == 2'd2) |-> s1_fend_q)
    else $error("two words from a pixel that is not a frame end");
`endif

endmodule

`default_nettype wire
